@@ hw/rtl/spq_pkg.sv @@
// Shared types and codes for the sorted priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  // Operation codes carried in the mode field
  localparam logic [1:0] MODE_ENQ  = 2'd0;
  localparam logic [1:0] MODE_DEQ  = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 5;

  // Input transaction payload
  typedef struct packed {
    logic        [1:0]        mode;
    logic signed [DATA_W-1:0] item_value;
    logic signed [DATA_W-1:0] item_rank;
  } spq_in_t;

  // Result transaction payload
  typedef struct packed {
    logic signed [DATA_W-1:0] head_value;
    logic        [1:0]        status;
    logic        [OCC_W-1:0]  occupancy;
  } spq_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } spq_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/spq_ctrl.sv @@
// Controller: sequences capture and execute, owns the handshake state.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  output spq_cmd_t      cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  // Output register may be loaded when empty or being drained this cycle
  assign out_free = !out_valid_r || !out_stall;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // Decode next state and datapath commands
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          cmd.execute = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Set on a new result, drop when the result transaction completes
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Never overwrite a result that is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |-> !(out_valid_r && out_stall))
    else $error("result overwritten while stalled");

  // A captured transaction always blocks the input on the next cycle
  a_capture_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> in_stall)
    else $error("input not blocked after capture");

  // Capture and execute never coincide
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.capture && cmd.execute))
    else $error("capture and execute at once");

endmodule

`default_nettype wire

@@ hw/rtl/spq_datapath.sv @@
// Datapath: sorted slot row with parallel compare and shift, result register.
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire spq_cmd_t cmd,
  input  wire spq_in_t  in_data,
  output spq_out_t      out_data
);

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  spq_in_t                   in_r;
  spq_out_t                  out_r, out_nxt;
  logic        [CNT_W-1:0]   fill_r, fill_nxt;
  logic signed [DATA_W-1:0]  rank_r  [QUEUE_DEPTH];
  logic signed [DATA_W-1:0]  value_r [QUEUE_DEPTH];
  logic signed [DATA_W-1:0]  rank_nxt  [QUEUE_DEPTH];
  logic signed [DATA_W-1:0]  value_nxt [QUEUE_DEPTH];
  logic        [QUEUE_DEPTH-1:0] gt;
  logic                      is_full, is_empty;
  logic                      do_enq, do_deq;
  logic [CNT_W+OCC_W-1:0]    occ_wide;

  assign is_full  = (fill_r == FULL_CNT);
  assign is_empty = (fill_r == '0);
  assign do_enq   = cmd.execute && (in_r.mode == MODE_ENQ) && !is_full;
  assign do_deq   = cmd.execute && (in_r.mode == MODE_DEQ) && !is_empty;

  // Per slot: stored entry outranks the new one (a prefix, since sorted)
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_slot
    assign gt[i] = (CNT_W'(i) < fill_r) &&
                   ($signed(rank_r[i]) > $signed(in_r.item_rank));

    // Keep, insert here, or shift from the neighbor
    always_comb begin
      rank_nxt[i]  = rank_r[i];
      value_nxt[i] = value_r[i];
      if (do_enq && !gt[i]) begin
        if (i == 0) begin
          rank_nxt[i]  = in_r.item_rank;
          value_nxt[i] = in_r.item_value;
        end else if (gt[(i == 0) ? 0 : i - 1]) begin
          rank_nxt[i]  = in_r.item_rank;
          value_nxt[i] = in_r.item_value;
        end else begin
          rank_nxt[i]  = rank_r[(i == 0) ? 0 : i - 1];
          value_nxt[i] = value_r[(i == 0) ? 0 : i - 1];
        end
      end else if (do_deq && (i < QUEUE_DEPTH - 1)) begin
        rank_nxt[i]  = rank_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
        value_nxt[i] = value_r[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  // Advance the fill count
  always_comb begin
    fill_nxt = fill_r;
    if (do_enq) begin
      fill_nxt = fill_r + CNT_W'(1);
    end else if (do_deq) begin
      fill_nxt = fill_r - CNT_W'(1);
    end
  end

  assign occ_wide = {{OCC_W{1'b0}}, fill_nxt};

  // Build the result of the captured transaction
  always_comb begin
    out_nxt.head_value = '0;
    out_nxt.status     = ST_OK;
    out_nxt.occupancy  = occ_wide[OCC_W-1:0];
    case (in_r.mode)
      MODE_ENQ: begin
        if (is_full) begin
          out_nxt.status = ST_FULL;
        end
      end
      MODE_DEQ, MODE_PEEK: begin
        if (is_empty) begin
          out_nxt.status = ST_EMPTY;
        end else begin
          out_nxt.head_value = value_r[0];
        end
      end
      default: ;
    endcase
  end

  // Fill count is control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  // Payload registers: input, slots, result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_r <= in_data;
    end
    if (cmd.execute) begin
      out_r <= out_nxt;
    end
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      rank_r[k]  <= rank_nxt[k];
      value_r[k] <= value_nxt[k];
    end
  end

  assign out_data = out_r;

  // Count stays within the store
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_CNT)
    else $error("fill count beyond depth");

  // A dequeue from a nonempty store removes exactly one entry
  a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
    do_deq |=> fill_r == $past(fill_r) - CNT_W'(1))
    else $error("dequeue count mismatch");

  // An enqueue into a full store leaves the count alone
  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute && (in_r.mode == MODE_ENQ) && is_full |=> fill_r == FULL_CNT)
    else $error("dropped enqueue changed the count");

endmodule

`default_nettype wire

@@ hw/rtl/sorted_priority_queue.sv @@
// Top level of the sorted priority queue: controller plus datapath.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall   in_data  (spq_in_t)
//   out      output     out_valid / out_stall out_data (spq_out_t)
//
// Each transaction is first captured into the input register; then all slots are
// compared in parallel, the slot row shifts and the result register loads.
// A new input is taken while the previous result waits in the output register.
// Execution waits only while the output register is full and stalled.
// Reset clears the fill count and handshake state; slot contents need no clear.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire spq_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output spq_out_t     out_data
);

  spq_cmd_t cmd;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

@@ dv/sorted_priority_queue_check.sv @@
// Scoreboard for the sorted priority queue: predicts each result and compares it.
`timescale 1ns / 1ps

module sorted_priority_queue_check
  import spq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_stall,
  input  wire spq_in_t  in_data,
  input  wire logic     out_valid,
  input  wire logic     out_stall,
  input  wire spq_out_t out_data,
  output int            fail_count,
  output int            pending
);

  // Shadow copy of the sorted store, highest rank at index 0
  logic signed [DATA_W-1:0] shadow_value [QUEUE_DEPTH];
  logic signed [DATA_W-1:0] shadow_rank  [QUEUE_DEPTH];
  int                       shadow_fill;

  spq_out_t awaited_replies [$];
  spq_out_t want;
  int       errs = 0;

  // Apply one request to the shadow store and return the reply it should produce
  function automatic spq_out_t serve_request(spq_in_t req);
    spq_out_t                 rsp;
    logic signed [DATA_W-1:0] rank;
    int                       pos;
    int                       i;
    rsp  = '0;
    rank = req.item_rank;
    case (req.mode)
      MODE_ENQ: begin
        if (shadow_fill >= QUEUE_DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          // insert ahead of the first entry whose rank is not greater
          pos = 0;
          while (pos < shadow_fill && shadow_rank[pos] > rank) pos++;
          for (i = shadow_fill; i > pos; i--) begin
            shadow_value[i] = shadow_value[i-1];
            shadow_rank[i]  = shadow_rank[i-1];
          end
          shadow_value[pos] = req.item_value;
          shadow_rank[pos]  = rank;
          shadow_fill++;
        end
      end
      MODE_DEQ, MODE_PEEK: begin
        if (shadow_fill == 0) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.head_value = shadow_value[0];
          if (req.mode == MODE_DEQ) begin
            for (i = 1; i < shadow_fill; i++) begin
              shadow_value[i-1] = shadow_value[i];
              shadow_rank[i-1]  = shadow_rank[i];
            end
            shadow_fill--;
          end
        end
      end
      default: begin
        // unused mode: nothing moves
      end
    endcase
    rsp.occupancy = OCC_W'(shadow_fill);
    return rsp;
  endfunction

  // Compare each result transaction against the oldest prediction, then queue new ones
  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_fill = 0;
      awaited_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_replies.size() == 0) begin
          errs++;
          if (errs <= 10)
            $display("%0t: unexpected result head_value=%0d status=%0d occupancy=%0d",
                     $realtime, out_data.head_value, out_data.status, out_data.occupancy);
        end else begin
          want = awaited_replies.pop_front();
          if (out_data.head_value !== want.head_value || out_data.status !== want.status ||
              out_data.occupancy !== want.occupancy) begin
            errs++;
            if (errs <= 10)
              $display({"%0t: mismatch head_value exp %0d got %0d, status exp %0d got %0d,",
                        " occupancy exp %0d got %0d"}, $realtime,
                       want.head_value, out_data.head_value, want.status, out_data.status,
                       want.occupancy, out_data.occupancy);
          end
        end
      end
      if (in_valid && !in_stall) awaited_replies.push_back(serve_request(in_data));
    end
    fail_count <= errs;
    pending    <= awaited_replies.size();
  end

endmodule

@@ dv/sorted_priority_queue_test.sv @@
// Testbench top for the sorted priority queue: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module sorted_priority_queue_test;
  import spq_pkg::*;

  localparam int unsigned QUEUE_DEPTH  = 16;
  localparam int          RANDOM_ITEMS = 1600;
  localparam int          IDLE_LIMIT   = 3000;
  localparam logic [1:0]  MODE_NOP     = 2'd3;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_LONG} stall_style_t;
  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED} phase_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  spq_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  spq_out_t out_data;
  int       fail_count;
  int       pending;

  int           burst_left;
  int           idle_cycles = 0;
  stall_style_t stall_style = STALL_NONE;
  int           style_left  = 0;
  int           hold_left   = 0;

  sorted_priority_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  sorted_priority_queue_check #(.QUEUE_DEPTH(QUEUE_DEPTH)) i_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // End the run when nothing has been accepted for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // Receiver stalls: switch between styles, including stall-free stretches
  always @(negedge clk) begin
    if (style_left == 0) begin
      stall_style = stall_style_t'($urandom_range(3));
      style_left  = $urandom_range(256, 64);
    end else begin
      style_left--;
    end
    case (stall_style)
      STALL_NONE:  out_stall = 1'b0;
      STALL_LIGHT: out_stall = ($urandom_range(99) < 30);
      STALL_HEAVY: out_stall = ($urandom_range(99) < 75);
      default: begin
        if (hold_left == 0) begin
          out_stall = ~out_stall;
          hold_left = $urandom_range(30, 1);
        end else begin
          hold_left--;
        end
      end
    endcase
  end

  function automatic int pick_burst();
    if ($urandom_range(7) == 0) return $urandom_range(200, 50);
    return $urandom_range(16, 1);
  endfunction

  // Present one transaction, hold it until accepted, then maybe idle
  task automatic push_request(input logic [1:0] mode, input logic [31:0] value,
                              input logic [31:0] rank);
    spq_in_t req;
    req.mode       = mode;
    req.item_value = value;
    req.item_rank  = rank;
    @(negedge clk);
    in_data  = req;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(7)) @(negedge clk);
      burst_left = pick_burst();
    end
  endtask

  initial begin
    phase_t      phase;
    int          phase_left;
    int          pick;
    logic [1:0]  mode;
    logic [31:0] rank;
    int          n;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    burst_left = pick_burst();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty cases, rank extremes, ties, drain past empty
    push_request(MODE_PEEK, $urandom, $urandom);
    push_request(MODE_DEQ,  $urandom, $urandom);
    push_request(MODE_NOP,  $urandom, $urandom);
    push_request(MODE_ENQ,  32'h7fff_ffff, 32'h0000_0000);
    push_request(MODE_ENQ,  32'h8000_0000, 32'h7fff_ffff);
    push_request(MODE_ENQ,  32'h0000_0000, 32'h8000_0000);
    push_request(MODE_ENQ,  32'hffff_ffff, 32'hffff_ffff);
    push_request(MODE_ENQ,  32'h0000_0001, 32'h0000_0000);
    push_request(MODE_ENQ,  32'h0000_0002, 32'h0000_0000);
    push_request(MODE_PEEK, $urandom, $urandom);
    push_request(MODE_NOP,  $urandom, $urandom);
    repeat (7) push_request(MODE_DEQ, $urandom, $urandom);
    push_request(MODE_PEEK, $urandom, $urandom);

    // Random: phases that lean toward filling, draining or a mix
    phase      = PH_MIXED;
    phase_left = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase      = phase_t'($urandom_range(2));
        phase_left = $urandom_range(60, 10);
      end
      phase_left--;
      pick = $urandom_range(99);
      if (pick < 3) mode = MODE_NOP;
      else begin
        pick = $urandom_range(99);
        case (phase)
          PH_FILL:  mode = (pick < 80) ? MODE_ENQ : (pick < 92) ? MODE_DEQ : MODE_PEEK;
          PH_DRAIN: mode = (pick < 15) ? MODE_ENQ : (pick < 85) ? MODE_DEQ : MODE_PEEK;
          default:  mode = (pick < 45) ? MODE_ENQ : (pick < 80) ? MODE_DEQ : MODE_PEEK;
        endcase
      end
      // narrow ranks force ties, wide ranks exercise signed ordering
      pick = $urandom_range(9);
      if (pick < 4) rank = 32'($signed($urandom_range(7)) - 4);
      else if (pick < 8) rank = $urandom;
      else begin
        case ($urandom_range(3))
          0:       rank = 32'h7fff_ffff;
          1:       rank = 32'h8000_0000;
          2:       rank = 32'h0000_0000;
          default: rank = 32'hffff_ffff;
        endcase
      end
      push_request(mode, $urandom, rank);
    end

    // Drop valid, let results drain, then watch for stray results
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
